[sv/assert_macros.svh]
// Assertion macros shared by the watchdog RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// next-cycle implication
`define CHK_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

[sv/mchw_pkg.sv]
// Types and constants of the multi-channel heartbeat watchdog.
// No dependencies.
package mchw_pkg;

	localparam int SECS_W = 16;
	localparam int MISS_W = 8;
	localparam int CUM_W  = 32;
	localparam int CH_W   = 2;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 16;
	localparam int MAX_CH = 3;

	typedef logic [SECS_W-1:0] secs_t;
	typedef logic [MISS_W-1:0] miss_t;
	typedef logic [CUM_W-1:0]  cum_t;
	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [IDX_W-1:0]  cfg_idx_t;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KICK = 1'b1;

	localparam cfg_idx_t REG_ENABLE     = 3'd0;
	localparam cfg_idx_t REG_SECS       = 3'd1;
	localparam cfg_idx_t REG_PERIOD_BASE = 3'd2;
	localparam cfg_idx_t REG_LIMIT_BASE  = 3'd5;

	localparam secs_t SECS_RST = 16'd30;
	localparam secs_t PERIOD_RST [MAX_CH] = '{16'd60, 16'd120, 16'd240};
	localparam miss_t LIMIT_RST = 8'd4;

endpackage

[sv/multi_channel_heartbeat_watchdog.sv]
// Multi-channel heartbeat watchdog, top level.
// Uses mchw_pkg and assert_macros.svh.
//
// Each command transfer (tick or kick) lands in one input register and is
// resolved there: a tick updates all channels in parallel with a priority
// pick of the lowest failing channel, a kick updates its own channel, and the
// sticky trip record, which is also the result register, is updated. A new
// command is taken every cycle; the input side only stalls while a result
// waits on m_tready. The result valid flag out_valid_q is set from the input
// register valid_s1 when the command is resolved. After a trip all channel
// state freezes until reset and every result repeats the trip record.
// Configuration writes take effect at once and must only be made while idle.
module multi_channel_heartbeat_watchdog
	import mchw_pkg::*;
#(
	parameter int NUM_CHANNELS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_en,
	input  cfg_idx_t    cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // cmd[0], channel[2:1], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // tripped[0], failed_channel[2:1],
	                               // misses_at_trip[10:3],
	                               // cumulative_at_trip[42:11], zero pad
);

`include "assert_macros.svh"

	logic  enable_q;
	secs_t secs_q;
	secs_t period_q [NUM_CHANNELS];
	miss_t limit_q  [NUM_CHANNELS];

	secs_t elapsed_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] alive_q;
	miss_t misses_q [NUM_CHANNELS];
	cum_t  cum_q    [NUM_CHANNELS];

	logic  trip_q;
	chan_t trip_ch_q;
	miss_t trip_miss_q;
	cum_t  trip_cum_q;

	logic  valid_s1;
	logic  cmd_s1;
	chan_t ch_s1;
	logic  out_valid_q;

	logic  go;
	logic  do_tick;
	logic  do_kick;

	secs_t e_sat   [NUM_CHANNELS];
	cum_t  cum_sat [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] reach;
	logic [NUM_CHANNELS-1:0] fail;
	logic [NUM_CHANNELS-1:0] active;
	logic  trip_d;
	chan_t trip_ch_d;

	assign go       = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go;
	assign do_tick  = go && !trip_q && (cmd_s1 == CMD_TICK) && enable_q;
	assign do_kick  = go && !trip_q && (cmd_s1 == CMD_KICK) &&
		(32'(ch_s1) < NUM_CHANNELS);

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			logic [SECS_W:0] es;
			logic [CUM_W:0]  cs;
			es = {1'b0, elapsed_q[c]} + {1'b0, secs_q};
			e_sat[c] = es[SECS_W] ? '1 : es[SECS_W-1:0];
			cs = {1'b0, cum_q[c]} + {{(CUM_W-MISS_W+1){1'b0}}, misses_q[c]};
			cum_sat[c] = cs[CUM_W] ? '1 : cs[CUM_W-1:0];
			reach[c] = period_q[c] <= e_sat[c];
			fail[c]  = reach[c] && !alive_q[c] && !(misses_q[c] < limit_q[c]);
		end
	end

	// lowest failing channel wins; later channels are left untouched
	always_comb begin
		trip_d    = 1'b0;
		trip_ch_d = '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			active[c] = !trip_d;
			if (!trip_d && fail[c]) begin
				trip_d    = 1'b1;
				trip_ch_d = CH_W'(c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (go)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tdata[0];
			ch_s1  <= s_tdata[2:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			secs_q   <= SECS_RST;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				period_q[c] <= PERIOD_RST[c];
				limit_q[c]  <= LIMIT_RST;
			end
		end else if (cfg_en) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_SECS:   secs_q   <= cfg_data;
				default: begin
					for (int c = 0; c < NUM_CHANNELS; c++) begin
						if (cfg_index == REG_PERIOD_BASE + IDX_W'(c))
							period_q[c] <= cfg_data;
						if (cfg_index == REG_LIMIT_BASE + IDX_W'(c))
							limit_q[c] <= cfg_data[MISS_W-1:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q     <= '0;
			trip_q      <= 1'b0;
			trip_ch_q   <= '0;
			trip_miss_q <= '0;
			trip_cum_q  <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				elapsed_q[c] <= '0;
				misses_q[c]  <= '0;
				cum_q[c]     <= '0;
			end
		end else begin
			if (do_kick) begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (ch_s1 == CH_W'(c)) begin
						cum_q[c]    <= cum_sat[c];
						misses_q[c] <= '0;
						alive_q[c]  <= 1'b1;
					end
				end
			end
			if (do_tick) begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (active[c]) begin
						if (!reach[c]) begin
							elapsed_q[c] <= e_sat[c];
						end else begin
							elapsed_q[c] <= '0;
							if (alive_q[c])
								alive_q[c] <= 1'b0;
							else if (!fail[c])
								misses_q[c] <= misses_q[c] + miss_t'(1);
						end
					end
				end
				if (trip_d) begin
					trip_q      <= 1'b1;
					trip_ch_q   <= trip_ch_d;
					trip_miss_q <= misses_q[trip_ch_d];
					trip_cum_q  <= cum_sat[trip_ch_d];
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, trip_cum_q, trip_miss_q, trip_ch_q, trip_q};

	`CHK_NXT(a_trip_sticky, trip_q, trip_q)
	`CHK_NXT(a_trip_frozen, trip_q, $stable(trip_cum_q) && $stable(trip_ch_q))
	`CHK_IMP(a_trip_from_tick, $rose(trip_q), $past(do_tick))
	`CHK_IMP(a_trip_ch_range, trip_q, 32'(trip_ch_q) < NUM_CHANNELS)
	`CHK_IMP(a_stall_holds_input, valid_s1 && out_valid_q && !m_tready, !s_tready)

endmodule

[test/tb_multi_channel_heartbeat_watchdog.sv]
// Self-checking bench for the three-channel heartbeat watchdog: tick and kick streams
// with random flow control, checked against an in-bench prediction of the trip record.
// Depends on mchw_pkg and the multi_channel_heartbeat_watchdog top level.
module tb_multi_channel_heartbeat_watchdog
	import mchw_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH = 3;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic  tripped;
		chan_t chan;
		miss_t misses;
		cum_t  cumul;
	} trip_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_en = 1'b0;
	cfg_idx_t cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;

	// shadow of the register file
	logic  cfg_enable = 1'b0;
	secs_t cfg_secs = SECS_RST;
	secs_t cfg_period [NUM_CH] = PERIOD_RST;
	miss_t cfg_limit [NUM_CH] = '{default: LIMIT_RST};

	// predicted channel state
	secs_t elapsed [NUM_CH] = '{default: '0};
	logic  alive [NUM_CH] = '{default: 1'b0};
	miss_t misses [NUM_CH] = '{default: '0};
	cum_t  cumul [NUM_CH] = '{default: '0};
	trip_status_t trip_rec = '0;

	logic [7:0] cmd_q [$];
	trip_status_t status_q [$];
	trip_status_t got, want;

	int send_idle_pct = 29;
	int recv_idle_pct = 47;
	logic hold_rx = 1'b0;
	int errors = 0;
	int cycles = 0;

	multi_channel_heartbeat_watchdog #(.NUM_CHANNELS(NUM_CH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_en(cfg_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic void advance_watchdog(logic [7:0] item);
		logic cmd;
		chan_t ch;
		logic [SECS_W:0] sum;
		logic [CUM_W:0] total;
		logic done;
		int c;
		cmd = item[0];
		ch = item[2:1];
		if (!trip_rec.tripped) begin
			if (cmd == CMD_TICK) begin
				if (cfg_enable) begin
					done = 1'b0;
					for (c = 0; c < NUM_CH && !done; c++) begin
						sum = {1'b0, elapsed[c]} + {1'b0, cfg_secs};
						elapsed[c] = sum[SECS_W] ? '1 : sum[SECS_W-1:0];
						if (elapsed[c] >= cfg_period[c]) begin
							elapsed[c] = '0;
							if (alive[c]) begin
								alive[c] = 1'b0;
							end else if (misses[c] < cfg_limit[c]) begin
								misses[c] = misses[c] + miss_t'(1);
							end else begin
								total = {1'b0, cumul[c]} +
									{{(CUM_W-MISS_W+1){1'b0}}, misses[c]};
								trip_rec.tripped = 1'b1;
								trip_rec.chan = c[CH_W-1:0];
								trip_rec.misses = misses[c];
								trip_rec.cumul = total[CUM_W] ? '1 : total[CUM_W-1:0];
								done = 1'b1;
							end
						end
					end
				end
			end else if (ch < NUM_CH) begin
				total = {1'b0, cumul[ch]} + {{(CUM_W-MISS_W+1){1'b0}}, misses[ch]};
				cumul[ch] = total[CUM_W] ? '1 : total[CUM_W-1:0];
				misses[ch] = '0;
				alive[ch] = 1'b1;
			end
		end
		status_q.push_back(trip_rec);
	endfunction

	function automatic logic [7:0] make_cmd(logic cmd, int ch);
		return {5'b0, chan_t'(ch), cmd};
	endfunction

	function automatic logic [7:0] rand_cmd(int kick_pct);
		int ch;
		ch = ($urandom_range(7, 0) == 0) ? 3 : int'($urandom_range(2, 0));
		return make_cmd(($urandom_range(99, 0) < kick_pct) ? CMD_KICK : CMD_TICK, ch);
	endfunction

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				advance_watchdog(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= cmd_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.tripped = m_tdata[0];
				got.chan = m_tdata[2:1];
				got.misses = m_tdata[10:3];
				got.cumul = m_tdata[42:11];
				if (status_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result with none pending: tripped=%0d ch=%0d",
							got.tripped, got.chan,
							" misses=%0d cum=%0d", got.misses, got.cumul);
				end else begin
					want = status_q.pop_front();
					if (got.tripped !== want.tripped || got.chan !== want.chan ||
						got.misses !== want.misses || got.cumul !== want.cumul) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: exp tripped=%0d ch=%0d misses=%0d cum=%0d",
								want.tripped, want.chan, want.misses, want.cumul);
							$display("          got tripped=%0d ch=%0d misses=%0d cum=%0d",
								got.tripped, got.chan, got.misses, got.cumul);
						end
					end
				end
			end
			m_tready <= !hold_rx && ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_multi_channel_heartbeat_watchdog: done, errors");
			$finish;
		end
	end

	// long receiver stall once the no-idle phase is under way
	initial begin
		wait (send_idle_pct == 0 && recv_idle_pct == 0);
		repeat (20) @(posedge clk);
		hold_rx <= 1'b1;
		repeat (120) @(posedge clk);
		hold_rx <= 1'b0;
	end

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(logic en, secs_t secs, secs_t p0, secs_t p1, secs_t p2,
		miss_t l0, miss_t l1, miss_t l2);
		cfg_enable = en;
		cfg_secs = secs;
		cfg_period = '{p0, p1, p2};
		cfg_limit = '{l0, l1, l2};
		write_reg(REG_ENABLE, CFG_W'(en));
		write_reg(REG_SECS, secs);
		for (int c = 0; c < NUM_CH; c++)
			write_reg(cfg_idx_t'(REG_PERIOD_BASE + c), cfg_period[c]);
		for (int c = 0; c < NUM_CH; c++)
			write_reg(cfg_idx_t'(REG_LIMIT_BASE + c), CFG_W'(cfg_limit[c]));
		cfg_en <= 1'b0;
	endtask

	task automatic random_config();
		secs_t secs;
		secs = secs_t'($urandom_range(200, 1));
		set_config($urandom_range(9, 0) != 0, secs,
			secs_t'($urandom_range(4 * secs, 1)), secs_t'($urandom_range(4 * secs, 1)),
			secs_t'($urandom_range(4 * secs, 1)),
			miss_t'($urandom_range(255, 16)), miss_t'($urandom_range(255, 16)),
			miss_t'($urandom_range(255, 16)));
	endtask

	task automatic drain();
		while (cmd_q.size() != 0 || s_tvalid || status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_random(int count, int kick_pct);
		repeat (count) cmd_q.push_back(rand_cmd(kick_pct));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, checking off: ticks ignored, kicks land, channel 3 ignored
		cmd_q.push_back(make_cmd(CMD_TICK, 0));
		cmd_q.push_back(make_cmd(CMD_KICK, 0));
		cmd_q.push_back(make_cmd(CMD_KICK, 1));
		cmd_q.push_back(make_cmd(CMD_KICK, 2));
		cmd_q.push_back(make_cmd(CMD_KICK, 3));
		cmd_q.push_back(make_cmd(CMD_TICK, 3));
		drain();

		// default periods with checking on
		set_config(1'b1, SECS_RST, PERIOD_RST[0], PERIOD_RST[1], PERIOD_RST[2],
			LIMIT_RST, LIMIT_RST, LIMIT_RST);
		repeat (4) cmd_q.push_back(make_cmd(CMD_TICK, 0));
		cmd_q.push_back(make_cmd(CMD_KICK, 0));
		drain();

		// largest step and periods: elapsed reaches its maximum
		set_config(1'b1, '1, '1, '1, '1, '1, '1, '1);
		repeat (3) cmd_q.push_back(make_cmd(CMD_TICK, 2));
		cmd_q.push_back(make_cmd(CMD_KICK, 1));
		cmd_q.push_back(make_cmd(CMD_KICK, 3));
		drain();

		// zero step, zero period on channel 0
		set_config(1'b1, '0, '0, '1, '1, '1, 8'd0, 8'd0);
		repeat (2) cmd_q.push_back(make_cmd(CMD_TICK, 1));
		cmd_q.push_back(make_cmd(CMD_KICK, 2));
		drain();

		// smallest nonzero step and period
		set_config(1'b1, 16'd1, 16'd1, 16'd1, 16'd1, '1, '1, '1);
		repeat (2) cmd_q.push_back(make_cmd(CMD_TICK, 0));
		cmd_q.push_back(make_cmd(CMD_KICK, 0));
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 47 : 0;
			recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 29 : 0;
			repeat (2) begin
				random_config();
				queue_random(75, 50);
				drain();
			end
		end

		// small tolerances on channels 1 and 2 to force a trip, then sticky results
		set_config(1'b1, 16'd10, 16'd10, 16'd20, 16'd20, '1,
			miss_t'($urandom_range(3, 0)), miss_t'($urandom_range(3, 0)));
		queue_random(40, 20);
		repeat (14) cmd_q.push_back(make_cmd(CMD_TICK, 0));
		queue_random(20, 50);
		drain();
		repeat (8) @(posedge clk);

		if (errors == 0 && status_q.size() == 0) begin
			$display("tb_multi_channel_heartbeat_watchdog: done, clean");
		end else begin
			$display("tb_multi_channel_heartbeat_watchdog: done, errors");
		end
		$finish;
	end

endmodule
